// File: rtl/core/lrupr_pkg.sv
package lrupr_pkg;

   // Fixed field widths of the block's ports
   localparam int CFG_W         = 5;
   localparam int FRAME_INDEX_W = 4;
   localparam int COUNT_W       = 32;

   // frames_in_use after reset
   localparam logic [CFG_W-1:0] FRAMES_RESET = 5'd16;

   // Depth of the queue between front and back
   localparam int QUEUE_DEPTH = 2;

endpackage

// File: rtl/core/lru_page_replacement.sv
// Channel   Direction  Handshake              Contents
// req_      in         req_valid/req_ready    page_number of one reference
// rsp_      out        rsp_valid/rsp_ready    hit, frame, evicted page, fault/hit totals
// csr_      in         csr_valid/csr_ready    frames_in_use (always ready)
//
// Each reference passes through the back end in order: S_FETCH compares all frames
// and picks the hit, first empty or oldest frame, then S_UPDATE writes page and ages.
// The next lookup waits for that age write, so the back end takes no new beat meanwhile.
// Synchronous reset clears valid marks, ages, counts and queue; frames_in_use = 16.
// A 2-entry queue decouples req_ from the back end; the result sits in an output
// register, and the back end takes a new beat as soon as that register is free.
module lru_page_replacement #(
   parameter int MAX_FRAMES = 16,
   parameter int PAGE_BITS  = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [PAGE_BITS-1:0]                req_page_number,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_hit,
   output logic [lrupr_pkg::FRAME_INDEX_W-1:0] rsp_frame_index,
   output logic                                rsp_evicted_valid,
   output logic [PAGE_BITS-1:0]                rsp_evicted_page,
   output logic [lrupr_pkg::COUNT_W-1:0]       rsp_fault_total,
   output logic [lrupr_pkg::COUNT_W-1:0]       rsp_hit_total,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [lrupr_pkg::CFG_W-1:0]         csr_frames_in_use
);
   import lrupr_pkg::*;

   logic                  head_valid;
   logic [PAGE_BITS-1:0]  head_page;
   logic                  head_pop;
   logic [MAX_FRAMES-1:0] active_mask;

   // Front: config register and reference queue
   lrupr_front #(
      .MAX_FRAMES (MAX_FRAMES),
      .PAGE_BITS  (PAGE_BITS)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_page_number   (req_page_number),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_frames_in_use (csr_frames_in_use),
      .head_valid        (head_valid),
      .head_page         (head_page),
      .head_pop          (head_pop),
      .active_mask       (active_mask)
   );

   // Back: frame table lookup, replacement and results
   lrupr_back #(
      .MAX_FRAMES (MAX_FRAMES),
      .PAGE_BITS  (PAGE_BITS)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .head_valid        (head_valid),
      .head_page         (head_page),
      .head_pop          (head_pop),
      .active_mask       (active_mask),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_hit           (rsp_hit),
      .rsp_frame_index   (rsp_frame_index),
      .rsp_evicted_valid (rsp_evicted_valid),
      .rsp_evicted_page  (rsp_evicted_page),
      .rsp_fault_total   (rsp_fault_total),
      .rsp_hit_total     (rsp_hit_total)
   );

endmodule

// File: rtl/core/lrupr_front.sv
module lrupr_front #(
   parameter int MAX_FRAMES = 16,
   parameter int PAGE_BITS  = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   // reference beats in
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [PAGE_BITS-1:0]        req_page_number,
   // frame count register
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [lrupr_pkg::CFG_W-1:0] csr_frames_in_use,
   // queue head toward the back end
   output logic                        head_valid,
   output logic [PAGE_BITS-1:0]        head_page,
   input  logic                        head_pop,
   // frames taking part in lookup and replacement
   output logic [MAX_FRAMES-1:0]       active_mask
);
   import lrupr_pkg::*;

   localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   logic [CFG_W-1:0]     cfg_ff;
   logic [PAGE_BITS-1:0] queue_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]    wr_ptr_ff;
   logic [QPTR_W-1:0]    rd_ptr_ff;
   logic [QCNT_W-1:0]    count_ff;
   logic [QCNT_W-1:0]    count_in;
   logic                 push;
   logic                 pop;

   assign csr_ready  = 1'b1;
   assign req_ready  = (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign push       = req_valid && req_ready;
   assign pop        = head_pop && head_valid;
   assign head_valid = (count_ff != '0);
   assign head_page  = queue_ff[rd_ptr_ff];

   // Frame 0 always takes part; counts above the frame total select all frames
   always_comb begin
      for (int g = 0; g < MAX_FRAMES; g++) begin
         active_mask[g] = (g == 0) || (32'(g) < 32'(cfg_ff));
      end
   end

   always_comb begin
      count_in = count_ff;
      priority case ({push, pop})
         2'b10:   count_in = count_ff + QCNT_W'(1);
         2'b01:   count_in = count_ff - QCNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   // Config register and queue control
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff    <= FRAMES_RESET;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (csr_valid) begin
            cfg_ff <= csr_frames_in_use;
         end
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
         end
         count_ff <= count_in;
      end
   end

   // Queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= req_page_number;
      end
   end

endmodule

// File: rtl/core/lrupr_back.sv
module lrupr_back #(
   parameter int MAX_FRAMES = 16,
   parameter int PAGE_BITS  = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   // queue head
   input  logic                                head_valid,
   input  logic [PAGE_BITS-1:0]                head_page,
   output logic                                head_pop,
   input  logic [MAX_FRAMES-1:0]               active_mask,
   // result beats out
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_hit,
   output logic [lrupr_pkg::FRAME_INDEX_W-1:0] rsp_frame_index,
   output logic                                rsp_evicted_valid,
   output logic [PAGE_BITS-1:0]                rsp_evicted_page,
   output logic [lrupr_pkg::COUNT_W-1:0]       rsp_fault_total,
   output logic [lrupr_pkg::COUNT_W-1:0]       rsp_hit_total
);
   import lrupr_pkg::*;

   localparam int IDX_W  = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
   localparam int RANK_W = IDX_W;
   localparam logic [RANK_W-1:0] AGE_MAX = RANK_W'(MAX_FRAMES - 1);

   typedef enum logic {S_FETCH, S_UPDATE} state_type;

   state_type            state_ff;

   // frame table
   logic [PAGE_BITS-1:0] page_ff  [MAX_FRAMES];
   logic [MAX_FRAMES-1:0] valid_ff;
   logic [RANK_W-1:0]    rank_ff  [MAX_FRAMES];
   logic [RANK_W-1:0]    rank_in  [MAX_FRAMES];
   logic [COUNT_W-1:0]   fault_ff;
   logic [COUNT_W-1:0]   fault_in;
   logic [COUNT_W-1:0]   hits_ff;
   logic [COUNT_W-1:0]   hits_in;

   // lookup results held for the update cycle
   logic [PAGE_BITS-1:0] lk_page_ff;
   logic [IDX_W-1:0]     lk_target_ff;
   logic                 lk_hit_ff;
   logic                 lk_evict_ff;
   logic [PAGE_BITS-1:0] lk_ev_page_ff;
   logic [RANK_W-1:0]    lk_old_rank_ff;
   logic                 lk_was_valid_ff;

   // result register
   logic                 rsp_valid_ff;
   logic                 rsp_hit_ff;
   logic [FRAME_INDEX_W-1:0] rsp_index_ff;
   logic                 rsp_ev_valid_ff;
   logic [PAGE_BITS-1:0] rsp_ev_page_ff;
   logic [COUNT_W-1:0]   rsp_fault_ff;
   logic [COUNT_W-1:0]   rsp_hits_ff;

   // lookup terms
   logic [MAX_FRAMES-1:0] match;
   logic [MAX_FRAMES-1:0] empty;
   logic [MAX_FRAMES-1:0] oldest;
   logic                  any_hit;
   logic                  any_empty;
   logic [IDX_W-1:0]      hit_idx;
   logic [IDX_W-1:0]      empty_idx;
   logic [IDX_W-1:0]      victim_idx;
   logic [IDX_W-1:0]      target_idx;

   assign head_pop = (state_ff == S_FETCH) && head_valid && (!rsp_valid_ff || rsp_ready);

   // Parallel compare, first empty frame, and oldest frame
   always_comb begin
      for (int g = 0; g < MAX_FRAMES; g++) begin
         match[g]  = active_mask[g] && valid_ff[g] && (page_ff[g] == head_page);
         empty[g]  = active_mask[g] && !valid_ff[g];
         oldest[g] = active_mask[g];
         for (int h = 0; h < MAX_FRAMES; h++) begin
            if (active_mask[h] && (rank_ff[h] > rank_ff[g])) begin
               oldest[g] = 1'b0;
            end
         end
      end
      any_hit   = |match;
      any_empty = |empty;
      hit_idx    = '0;
      empty_idx  = '0;
      victim_idx = '0;
      // walk down so the lowest index wins
      for (int g = MAX_FRAMES - 1; g >= 0; g--) begin
         if (match[g])  hit_idx    = IDX_W'(g);
         if (empty[g])  empty_idx  = IDX_W'(g);
         if (oldest[g]) victim_idx = IDX_W'(g);
      end
      priority if (any_hit)   target_idx = hit_idx;
      else if (any_empty)     target_idx = empty_idx;
      else                    target_idx = victim_idx;
   end

   // Age update: used frame goes to zero, younger valid active frames age by one
   always_comb begin
      for (int g = 0; g < MAX_FRAMES; g++) begin
         rank_in[g] = rank_ff[g];
         if (IDX_W'(g) == lk_target_ff) begin
            rank_in[g] = '0;
         end else if (active_mask[g] && valid_ff[g]
                      && (!lk_was_valid_ff || (rank_ff[g] < lk_old_rank_ff))
                      && (rank_ff[g] < AGE_MAX)) begin
            rank_in[g] = rank_ff[g] + RANK_W'(1);
         end
      end
      fault_in = fault_ff;
      hits_in  = hits_ff;
      if (lk_hit_ff) begin
         if (hits_ff != '1) hits_in = hits_ff + COUNT_W'(1);
      end else begin
         if (fault_ff != '1) fault_in = fault_ff + COUNT_W'(1);
      end
   end

   // Sequencer, frame state and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_FETCH;
         valid_ff     <= '0;
         fault_ff     <= '0;
         hits_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         for (int g = 0; g < MAX_FRAMES; g++) begin
            rank_ff[g] <= '0;
         end
      end else begin
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_FETCH: begin
               if (head_pop) begin
                  lk_page_ff      <= head_page;
                  lk_target_ff    <= target_idx;
                  lk_hit_ff       <= any_hit;
                  lk_evict_ff     <= !any_hit && !any_empty;
                  lk_ev_page_ff   <= (!any_hit && !any_empty) ? page_ff[victim_idx] : '0;
                  lk_old_rank_ff  <= rank_ff[target_idx];
                  lk_was_valid_ff <= valid_ff[target_idx];
                  state_ff        <= S_UPDATE;
               end
            end
            S_UPDATE: begin
               page_ff[lk_target_ff]  <= lk_page_ff;
               valid_ff[lk_target_ff] <= 1'b1;
               for (int g = 0; g < MAX_FRAMES; g++) begin
                  rank_ff[g] <= rank_in[g];
               end
               fault_ff        <= fault_in;
               hits_ff         <= hits_in;
               rsp_valid_ff    <= 1'b1;
               rsp_hit_ff      <= lk_hit_ff;
               rsp_index_ff    <= FRAME_INDEX_W'(lk_target_ff);
               rsp_ev_valid_ff <= lk_evict_ff;
               rsp_ev_page_ff  <= lk_ev_page_ff;
               rsp_fault_ff    <= fault_in;
               rsp_hits_ff     <= hits_in;
               state_ff        <= S_FETCH;
            end
            default: state_ff <= S_FETCH;
         endcase
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_hit           = rsp_hit_ff;
   assign rsp_frame_index   = rsp_index_ff;
   assign rsp_evicted_valid = rsp_ev_valid_ff;
   assign rsp_evicted_page  = rsp_ev_page_ff;
   assign rsp_fault_total   = rsp_fault_ff;
   assign rsp_hit_total     = rsp_hits_ff;

   // The result slot is always free when an update lands
   a_slot_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_UPDATE) |-> !rsp_valid_ff)
      else $error("update with result slot occupied");

   // A beat never reports both a hit and an eviction
   a_hit_no_evict: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_hit_ff && rsp_ev_valid_ff))
      else $error("hit reported with eviction");

   // The frame just written is valid and most recently used
   a_target_mru: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_UPDATE) |=> (valid_ff[$past(lk_target_ff)]
                                  && (rank_ff[$past(lk_target_ff)] == '0)))
      else $error("target frame not marked most recent");

   // One count moves per finished reference, unless that count is saturated
   a_one_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_UPDATE) |=> ((fault_ff != $past(fault_ff)) || (hits_ff != $past(hits_ff))
                                  || (fault_ff == '1) || (hits_ff == '1)))
      else $error("no count advanced");

endmodule

// File: test/tb_lru_page_replacement.sv
// One response beat of the LRU block
typedef struct packed {
   logic        hit;
   logic [3:0]  frame_index;
   logic        evicted_valid;
   logic [15:0] evicted_page;
   logic [31:0] fault_total;
   logic [31:0] hit_total;
} lru_result_type;

// Shadow of the frame table plus the queue of responses still owed
class lru_scoreboard;
   localparam int FRAMES_MAX = 16;
   localparam logic [3:0] AGE_MAX = 4'(FRAMES_MAX - 1);

   logic [15:0]    page_of [FRAMES_MAX];
   bit             resident [FRAMES_MAX];
   bit [3:0]       age [FRAMES_MAX];
   bit [31:0]      faults;
   bit [31:0]      hits;
   bit [4:0]       frames_cfg;
   lru_result_type owed_q[$];
   int unsigned    mismatches;

   function new();
      for (int f = 0; f < FRAMES_MAX; f++) begin
         page_of[f]  = '0;
         resident[f] = 1'b0;
         age[f]      = '0;
      end
      faults     = '0;
      hits       = '0;
      frames_cfg = lrupr_pkg::FRAMES_RESET;
      mismatches = 0;
   endfunction

   function void set_frames(bit [4:0] value);
      frames_cfg = value;
   endfunction

   function int unsigned outstanding();
      return owed_q.size();
   endfunction

   // Replacement decision and age update for one accepted reference
   function void note_ref(logic [15:0] page);
      int             n;
      int             target;
      bit             found;
      bit             was_resident;
      bit [3:0]       old_age;
      lru_result_type res;

      n = (frames_cfg == 0) ? 1 : ((frames_cfg > FRAMES_MAX) ? FRAMES_MAX : frames_cfg);
      res    = '0;
      target = 0;
      found  = 1'b0;

      // lowest matching index wins when a page sits in two frames
      for (int f = 0; f < n; f++) begin
         if (!found && resident[f] && page_of[f] == page) begin
            found  = 1'b1;
            target = f;
         end
      end

      if (found) begin
         res.hit = 1'b1;
         if (hits != '1) hits++;
      end else begin
         // first empty frame, else the lowest index of the oldest age
         for (int f = 0; f < n; f++) begin
            if (!found && !resident[f]) begin
               found  = 1'b1;
               target = f;
            end
         end
         if (!found) begin
            target = 0;
            for (int f = 1; f < n; f++)
               if (age[f] > age[target]) target = f;
            res.evicted_valid = 1'b1;
            res.evicted_page  = page_of[target];
         end
         if (faults != '1) faults++;
      end

      // younger valid frames age by one; a fresh fill ages all of them
      was_resident = resident[target];
      old_age      = age[target];
      for (int g = 0; g < n; g++) begin
         if (g != target && resident[g] && (!was_resident || age[g] < old_age))
            if (age[g] < AGE_MAX) age[g]++;
      end
      age[target]      = '0;
      page_of[target]  = page;
      resident[target] = 1'b1;

      res.frame_index = 4'(target);
      res.fault_total = faults;
      res.hit_total   = hits;
      owed_q.push_back(res);
   endfunction

   function void check_rsp(lru_result_type got);
      lru_result_type want;
      if (owed_q.size() == 0) begin
         $error("response beat with nothing outstanding");
         mismatches++;
         return;
      end
      want = owed_q.pop_front();
      if (got.hit !== want.hit) begin
         $error("hit expected %0h got %0h", want.hit, got.hit);
         mismatches++;
      end
      if (got.frame_index !== want.frame_index) begin
         $error("frame_index expected %0h got %0h", want.frame_index, got.frame_index);
         mismatches++;
      end
      if (got.evicted_valid !== want.evicted_valid) begin
         $error("evicted_valid expected %0h got %0h", want.evicted_valid, got.evicted_valid);
         mismatches++;
      end
      if (got.evicted_page !== want.evicted_page) begin
         $error("evicted_page expected %0h got %0h", want.evicted_page, got.evicted_page);
         mismatches++;
      end
      if (got.fault_total !== want.fault_total) begin
         $error("fault_total expected %0h got %0h", want.fault_total, got.fault_total);
         mismatches++;
      end
      if (got.hit_total !== want.hit_total) begin
         $error("hit_total expected %0h got %0h", want.hit_total, got.hit_total);
         mismatches++;
      end
   endfunction
endclass

module tb_lru_page_replacement;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_FRAMES  = 16;
   localparam int PAGE_BITS   = 16;
   localparam int POOL_SIZE   = 24;
   localparam int PHASES      = 13;
   localparam int PHASE_ITEMS = 146;

   logic                                clock;
   logic                                reset;
   logic                                req_valid;
   logic                                req_ready;
   logic [PAGE_BITS-1:0]                req_page_number;
   logic                                rsp_valid;
   logic                                rsp_ready;
   logic                                rsp_hit;
   logic [lrupr_pkg::FRAME_INDEX_W-1:0] rsp_frame_index;
   logic                                rsp_evicted_valid;
   logic [PAGE_BITS-1:0]                rsp_evicted_page;
   logic [lrupr_pkg::COUNT_W-1:0]       rsp_fault_total;
   logic [lrupr_pkg::COUNT_W-1:0]       rsp_hit_total;
   logic                                csr_valid;
   logic                                csr_ready;
   logic [lrupr_pkg::CFG_W-1:0]         csr_frames_in_use;

   lru_scoreboard sb = new();
   bit            send_burst;
   bit            rsp_burst;
   logic [15:0]   page_pool [POOL_SIZE];

   lru_page_replacement #(
      .MAX_FRAMES(MAX_FRAMES),
      .PAGE_BITS (PAGE_BITS)
   ) uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_page_number  (req_page_number),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_hit          (rsp_hit),
      .rsp_frame_index  (rsp_frame_index),
      .rsp_evicted_valid(rsp_evicted_valid),
      .rsp_evicted_page (rsp_evicted_page),
      .rsp_fault_total  (rsp_fault_total),
      .rsp_hit_total    (rsp_hit_total),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_frames_in_use(csr_frames_in_use)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Send one reference beat after an idle gap of the given length
   task automatic send_ref(input logic [15:0] page, input int gap);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_page_number <= page;
      do @(posedge clock); while (!req_ready);
      sb.note_ref(page);
   endtask

   function automatic int draw_gap();
      return send_burst ? 0 : $urandom_range(0, 9);
   endfunction

   // Stop sending and wait until every owed response is back
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Register write, only issued once the block is idle
   task automatic write_frames(input logic [4:0] value);
      drain();
      @(negedge clock);
      csr_valid         <= 1'b1;
      csr_frames_in_use <= value;
      do @(posedge clock); while (!csr_ready);
      sb.set_frames(value);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Response side: random stall before each beat, or none in burst stretches
   initial begin
      int stall;
      rsp_ready = 1'b1;
      @(negedge reset);
      forever begin
         stall = rsp_burst ? 0 : $urandom_range(0, 9);
         if (stall > 0) begin
            @(negedge clock);
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
            rsp_ready <= 1'b1;
         end
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
      end
   end

   // Check every accepted response beat
   always @(posedge clock) begin
      lru_result_type got;
      if (!reset && rsp_valid && rsp_ready) begin
         got.hit           = rsp_hit;
         got.frame_index   = rsp_frame_index;
         got.evicted_valid = rsp_evicted_valid;
         got.evicted_page  = rsp_evicted_page;
         got.fault_total   = rsp_fault_total;
         got.hit_total     = rsp_hit_total;
         sb.check_rsp(got);
      end
   end

   // Run limit
   initial begin
      #2_000_000;
      $display("Mismatches found");
      $finish;
   end

   // Stimulus
   initial begin
      logic [4:0]  cfg;
      logic [15:0] page;

      reset             = 1'b1;
      req_valid         = 1'b0;
      req_page_number   = '0;
      csr_valid         = 1'b0;
      csr_frames_in_use = lrupr_pkg::FRAMES_RESET;
      send_burst        = 1'b0;
      rsp_burst         = 1'b0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // fill all 16 frames with extreme and walking-one pages
      send_ref(16'h0000, 0);
      send_ref(16'hFFFF, 0);
      for (int k = 0; k < 14; k++) send_ref(16'h0001 << k, $urandom_range(0, 3));
      // hits on both extremes, then a fault that evicts the oldest frame
      send_ref(16'hFFFF, 0);
      send_ref(16'h0000, 2);
      send_ref(16'hABCD, 0);

      // shrink to two frames: page still held in frame 9 faults in again,
      // leaving the same page resident twice once the table grows back
      write_frames(5'd2);
      send_ref(16'h0080, 0);
      write_frames(5'd31);          // above the frame count, acts as 16
      send_ref(16'h0080, 0);
      write_frames(5'd0);           // zero acts as one frame
      send_ref(16'h5555, 0);
      send_ref(16'hAAAA, 0);

      for (int i = 0; i < POOL_SIZE; i++) page_pool[i] = 16'($urandom);

      // random phases, each under its own frame count
      for (int ph = 0; ph < PHASES; ph++) begin
         case (ph)
            0:       cfg = 5'd1;
            1:       cfg = 5'd16;
            2:       cfg = 5'd0;
            3:       cfg = 5'd31;
            4:       cfg = 5'd8;
            default: cfg = 5'($urandom_range(0, 31));
         endcase
         write_frames(cfg);
         send_burst = ($urandom_range(0, 3) == 0);
         rsp_burst  = ($urandom_range(0, 3) == 0);
         // keep half the pool so pages stay resident across a count change
         for (int i = 0; i < POOL_SIZE; i++)
            if ($urandom_range(0, 1) == 1) page_pool[i] = 16'($urandom);
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if (ph == 6 && i == PHASE_ITEMS / 2) drain();
            if ($urandom_range(0, 99) < 85)
               page = page_pool[$urandom_range(0, ($urandom_range(0, 1) == 1) ?
                                               POOL_SIZE - 1 : 11)];
            else
               page = 16'($urandom);
            send_ref(page, draw_gap());
         end
      end

      drain();
      repeat (10) @(posedge clock);
      if (sb.mismatches == 0 && sb.outstanding() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
